// ===== rtl/core/alz_pkg.sv =====
// Alzette ARX-box package: round constants, per-mode widths, rotation amounts and round function.
`timescale 1ns / 1ps

package alz_pkg;

	localparam int unsigned HalfW   = 32;
	localparam int unsigned Rounds  = 4;
	localparam int unsigned ModeW   = 2;
	localparam int unsigned BranchW = 4;
	localparam int unsigned RotW    = 5;
	localparam int unsigned Latency = Rounds + 1;

	typedef logic [HalfW-1:0] half_t;
	typedef logic [ModeW-1:0] mode_t;
	typedef logic [RotW-1:0]  rot_t;

	typedef enum logic [ModeW-1:0] {
		MODE_W32 = 2'd0,
		MODE_W16 = 2'd1,
		MODE_W12 = 2'd2,
		MODE_W8  = 2'd3
	} width_mode_t;

	typedef struct packed {
		half_t x;
		half_t y;
	} pair_t;

	localparam half_t RoundConst [8] = '{
		32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
		32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
	};

	localparam half_t Mask12 = 32'h0000_0FFF;

	function automatic half_t half_mask(input mode_t mode);
		half_t m;
		case (mode)
			MODE_W32: m = 32'hFFFF_FFFF;
			MODE_W16: m = 32'h0000_FFFF;
			MODE_W12: m = Mask12;
			MODE_W8:  m = 32'h0000_00FF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] half_width(input mode_t mode);
		logic [5:0] w;
		case (mode)
			MODE_W32: w = 6'd32;
			MODE_W16: w = 6'd16;
			MODE_W12: w = 6'd12;
			MODE_W8:  w = 6'd8;
			default:  w = 6'd32;
		endcase
		return w;
	endfunction

	// idx: 2*round for the add rotation, 2*round+1 for the xor rotation
	function automatic rot_t rot_amount(input mode_t mode, input logic [2:0] idx);
		rot_t n;
		case (mode)
			MODE_W32: begin
				case (idx)
					3'd0: n = 5'd31;  3'd1: n = 5'd24;
					3'd2: n = 5'd17;  3'd3: n = 5'd17;
					3'd4: n = 5'd0;   3'd5: n = 5'd31;
					3'd6: n = 5'd24;  default: n = 5'd16;
				endcase
			end
			MODE_W16: begin
				case (idx)
					3'd0: n = 5'd15;  3'd1: n = 5'd12;
					3'd2: n = 5'd9;   3'd3: n = 5'd9;
					3'd4: n = 5'd0;   3'd5: n = 5'd15;
					3'd6: n = 5'd12;  default: n = 5'd8;
				endcase
			end
			MODE_W12: begin
				case (idx)
					3'd0: n = 5'd11;  3'd1: n = 5'd9;
					3'd2: n = 5'd7;   3'd3: n = 5'd7;
					3'd4: n = 5'd0;   3'd5: n = 5'd11;
					3'd6: n = 5'd9;   default: n = 5'd6;
				endcase
			end
			default: begin
				case (idx)
					3'd0: n = 5'd7;   3'd1: n = 5'd6;
					3'd2: n = 5'd5;   3'd3: n = 5'd5;
					3'd4: n = 5'd0;   3'd5: n = 5'd7;
					3'd6: n = 5'd6;   default: n = 5'd4;
				endcase
			end
		endcase
		return n;
	endfunction

	function automatic half_t rotr_w(input half_t v, input rot_t n, input mode_t mode);
		half_t      m;
		half_t      vm;
		logic [5:0] w;
		logic [5:0] lsh;
		half_t      r;
		m   = half_mask(mode);
		w   = half_width(mode);
		vm  = v & m;
		lsh = w - {1'b0, n};
		if (n == '0 || {1'b0, n} >= w) begin
			r = vm;
		end else begin
			r = ((vm >> n) | (vm << lsh)) & m;
		end
		return r;
	endfunction

	function automatic pair_t alz_round(input pair_t p, input half_t c, input mode_t mode,
		input logic [1:0] rnd);
		half_t m;
		half_t x;
		half_t y;
		pair_t q;
		m   = half_mask(mode);
		x   = (p.x + rotr_w(p.y, rot_amount(mode, {rnd, 1'b0}), mode)) & m;
		y   = (p.y ^ rotr_w(x, rot_amount(mode, {rnd, 1'b1}), mode)) & m;
		q.x = (x ^ c) & m;
		q.y = y;
		return q;
	endfunction

endpackage

// ===== rtl/core/alzette_arx_box_core.sv =====
// Alzette ARX-box core: five-stage pipeline, one input stage, then one ARX round per stage.
`timescale 1ns / 1ps
//
// Usage:
//   Input: drive word_x, word_y, branch_number and raise start; the item is
//   taken at each rising edge with start high and busy low. busy stays low,
//   so one item can enter in every cycle.
//   Output: done pulses for one cycle with out_x / out_y once the item has
//   passed the pipeline (one input stage, then one stage per round).
//   Throughput: one item per cycle, set by the one-round-per-stage pipeline.
//   Configuration: width_mode is written through cfg_valid / cfg_ready /
//   cfg_data; cfg_ready is high while no item is in flight and start is low.
//   Each item keeps the mode it entered with.
//   Reset: arst_n low clears all stage valid bits and sets width_mode to
//   32-bit halves; items in flight are dropped, no stale result follows.
//   The receiver cannot stall: each result is shown for exactly one cycle.

module alzette_arx_box_core
	import alz_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [HalfW-1:0]   word_x,
	input  logic [HalfW-1:0]   word_y,
	input  logic [BranchW-1:0] branch_number,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ModeW-1:0]   cfg_data,
	output logic               done,
	output logic [HalfW-1:0]   out_x,
	output logic [HalfW-1:0]   out_y
);

	mode_t width_mode_q;

	logic  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	mode_t mode_s1, mode_s2, mode_s3, mode_s4;
	half_t c_s1, c_s2, c_s3, c_s4;
	pair_t p_s1, p_s2, p_s3, p_s4, p_s5;

	logic  accept;
	half_t in_mask;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign cfg_ready = !(start || valid_s1 || valid_s2 || valid_s3 || valid_s4 || valid_s5);
	assign in_mask   = half_mask(width_mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= MODE_W32;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				width_mode_q <= cfg_data;
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		p_s1.x  <= word_x & in_mask;
		p_s1.y  <= word_y & in_mask;
		c_s1    <= RoundConst[branch_number[BranchW-1:1]] & in_mask;
		mode_s1 <= width_mode_q;

		p_s2    <= alz_round(p_s1, c_s1, mode_s1, 2'd0);
		c_s2    <= c_s1;
		mode_s2 <= mode_s1;

		p_s3    <= alz_round(p_s2, c_s2, mode_s2, 2'd1);
		c_s3    <= c_s2;
		mode_s3 <= mode_s2;

		p_s4    <= alz_round(p_s3, c_s3, mode_s3, 2'd2);
		c_s4    <= c_s3;
		mode_s4 <= mode_s3;

		p_s5    <= alz_round(p_s4, c_s4, mode_s4, 2'd3);
	end

	assign done  = valid_s5;
	assign out_x = p_s5.x;
	assign out_y = p_s5.y;

endmodule

// ===== rtl/core/alzette_arx_box_checker.sv =====
// Port-level checker for the Alzette ARX-box core, with its bind.
`timescale 1ns / 1ps

module alzette_arx_box_checker
	import alz_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_ready,
	input logic done
);

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency done)
		else $error("accepted item produced no result");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##Latency !done)
		else $error("result without an accepted item");

	a_idle_means_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |=> !done)
		else $error("result while config port reported idle");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind alzette_arx_box_core alzette_arx_box_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_ready (cfg_ready),
	.done      (done)
);

// ===== verif/tb_alzette_arx_box_core.sv =====
// Testbench for alzette_arx_box_core: random and directed word pairs in all width modes, scoreboard check.
`timescale 1ns / 1ps

module tb_alzette_arx_box_core;
	import alz_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 205;
	localparam int SETTLE_CYCLES = Latency + 3;

	localparam half_t BRANCH_CONSTS [8] = '{
		32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
		32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
	};

	class alzette_scoreboard;
		width_mode_t mode;
		pair_t       expected_pairs[$];
		int          errors;

		function new();
			mode   = MODE_W32;
			errors = 0;
		endfunction

		function void set_mode(mode_t m);
			mode = width_mode_t'(m);
		endfunction

		function half_t rot_right(half_t v, int n, int w, half_t mask);
			half_t vm;
			vm = v & mask;
			if (n == 0 || n >= w) begin
				return vm;
			end
			return ((vm >> n) | (vm << (w - n))) & mask;
		endfunction

		function pair_t alzette_box(half_t x_in, half_t y_in, logic [BranchW-1:0] br);
			int    w;
			half_t mask;
			int    add_rot[4];
			int    xor_rot[4];
			half_t rc;
			half_t x;
			half_t y;
			pair_t p;
			case (mode)
				MODE_W32: begin
					w = 32; mask = 32'hFFFF_FFFF;
					add_rot = '{31, 17, 0, 24}; xor_rot = '{24, 17, 31, 16};
				end
				MODE_W16: begin
					w = 16; mask = 32'h0000_FFFF;
					add_rot = '{15, 9, 0, 12}; xor_rot = '{12, 9, 15, 8};
				end
				MODE_W12: begin
					w = 12; mask = 32'h0000_0FFF;
					add_rot = '{11, 7, 0, 9}; xor_rot = '{9, 7, 11, 6};
				end
				default: begin
					w = 8; mask = 32'h0000_00FF;
					add_rot = '{7, 5, 0, 6}; xor_rot = '{6, 5, 7, 4};
				end
			endcase
			x  = x_in & mask;
			y  = y_in & mask;
			rc = BRANCH_CONSTS[br >> 1] & mask;
			for (int r = 0; r < 4; r++) begin
				x = (x + rot_right(y, add_rot[r], w, mask)) & mask;
				y = (y ^ rot_right(x, xor_rot[r], w, mask)) & mask;
				x = (x ^ rc) & mask;
			end
			p.x = x;
			p.y = y;
			return p;
		endfunction

		function void note_item(half_t x, half_t y, logic [BranchW-1:0] br);
			expected_pairs.push_back(alzette_box(x, y, br));
		endfunction

		function void check_result(half_t got_x, half_t got_y);
			pair_t want;
			if (expected_pairs.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result: out_x=%h out_y=%h", got_x, got_y);
				end
				return;
			end
			want = expected_pairs.pop_front();
			if (got_x !== want.x || got_y !== want.y) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: out_x exp %h got %h, out_y exp %h got %h",
						want.x, got_x, want.y, got_y);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               start         = 1'b0;
	logic               busy;
	logic [HalfW-1:0]   word_x        = '0;
	logic [HalfW-1:0]   word_y        = '0;
	logic [BranchW-1:0] branch_number = '0;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [ModeW-1:0]   cfg_data      = '0;
	logic               done;
	logic [HalfW-1:0]   out_x;
	logic [HalfW-1:0]   out_y;

	alzette_scoreboard sb;
	int                idle_cycles = 0;
	bit                no_gaps     = 1'b0;

	alzette_arx_box_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.word_x        (word_x),
		.word_y        (word_y),
		.branch_number (branch_number),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.out_x         (out_x),
		.out_y         (out_y)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_item(word_x, word_y, branch_number);
			end
			if (done) begin
				sb.check_result(out_x, out_y);
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_mode(cfg_data);
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic half_t pick_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return half_t'(1) << $urandom_range(0, HalfW - 1);
			3:       return ~(half_t'(1) << $urandom_range(0, HalfW - 1));
			default: return half_t'($urandom());
		endcase
	endfunction

	task automatic send_item(half_t x, half_t y, logic [BranchW-1:0] br);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		word_x        <= x;
		word_y        <= y;
		branch_number <= br;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width_mode(width_mode_t m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	width_mode_t phase_modes [6] = '{MODE_W8, MODE_W16, MODE_W12, MODE_W32, MODE_W8, MODE_W16};

	initial begin
		half_t edge_vals [4];
		sb = new();
		edge_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int b = 0; b < 16; b++) begin
			send_item(edge_vals[b % 4], edge_vals[(b / 4 + b) % 4], b[BranchW-1:0]);
		end

		for (int p = 0; p < 6; p++) begin
			write_width_mode(phase_modes[p]);
			no_gaps = (p == 1) || ($urandom_range(0, 3) == 0);
			if (p < 4) begin
				send_item('1, '1, 4'd15);
				send_item(32'hFFFF_FF00, 32'hFFFF_F000, 4'd0);
			end
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				send_item(pick_word(), pick_word(), BranchW'($urandom_range(0, 15)));
			end
		end

		drain();
		if (sb.expected_pairs.size() != 0) begin
			sb.errors++;
			$display("%0d expected results never arrived", sb.expected_pairs.size());
		end
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
